[rtl/ccirc_pkg.sv]
// Shared constants and pipeline stage types for the circumcircle block.
// No dependencies; every other file of the block imports it.
`default_nettype none
package ccirc_pkg;
   localparam int COORD_BITS = 11;
   localparam int FRAC_BITS  = 4;
   localparam int OUT_BITS   = 24;

   // determinant, squared norms, -B/-C terms, numerator, denominator
   localparam int AW  = 2 * COORD_BITS + 3;
   localparam int SW  = 2 * COORD_BITS + 1;
   localparam int PAW = 2 * COORD_BITS + 2;
   localparam int PBW = SW + COORD_BITS + 2;
   localparam int BW  = 3 * COORD_BITS + 4;
   localparam int NW  = BW + FRAC_BITS;
   localparam int DMW = AW + 1;
   localparam int QW  = NW + 1;
   localparam int CXW = QW + 1;
   localparam int XW  = CXW + 1;

   // square root of the squared radius
   localparam int SQW = 2 * OUT_BITS + 1;
   localparam int SQN = (SQW + 1) / 2;
   localparam int SQE = 2 * SQN;
   localparam int RTW = SQN;
   localparam int RW  = RTW + 2;

   typedef struct packed {
      logic [DMW-1:0]          rx;
      logic [DMW-1:0]          ry;
      logic [QW-1:0]           qx;
      logic [QW-1:0]           qy;
      logic [DMW-1:0]          den;
      logic                    negx;
      logic                    negy;
      logic [COORD_BITS-1:0]   x1;
      logic [COORD_BITS-1:0]   y1;
      logic                    vres;
   } div_stage_type;

   typedef struct packed {
      logic [RW-1:0]           rem;
      logic [RTW-1:0]          root;
      logic [SQE-1:0]          sv;
      logic                    vres;
      logic                    rsat;
      logic [OUT_BITS-1:0]     cx;
      logic [OUT_BITS-1:0]     cy;
   } sq_stage_type;
endpackage
`default_nettype wire

[rtl/ccirc_req_if.sv]
// Input channel: three points per beat, valid/ready handshake.
// Depends on ccirc_pkg for the coordinate width.
`default_nettype none
interface ccirc_req_if import ccirc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] first_x;
   logic [COORD_BITS-1:0] first_y;
   logic [COORD_BITS-1:0] second_x;
   logic [COORD_BITS-1:0] second_y;
   logic [COORD_BITS-1:0] third_x;
   logic [COORD_BITS-1:0] third_y;

   modport source (output valid, first_x, first_y, second_x, second_y, third_x, third_y,
                   input ready);
   modport sink (input valid, first_x, first_y, second_x, second_y, third_x, third_y,
                 output ready);
endinterface
`default_nettype wire

[rtl/ccirc_rsp_if.sv]
// Result channel: one circle per beat, valid/ready handshake.
// Depends on ccirc_pkg for the output width.
`default_nettype none
interface ccirc_rsp_if import ccirc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       valid_res;
   logic signed [OUT_BITS-1:0] center_x;
   logic signed [OUT_BITS-1:0] center_y;
   logic [OUT_BITS-1:0]        radius;

   modport source (output valid, valid_res, center_x, center_y, radius, input ready);
   modport sink (input valid, valid_res, center_x, center_y, radius, output ready);
endinterface
`default_nettype wire

[rtl/circumcircle_three_points.sv]
// Circumcircle of three pixel points: fully pipelined top level.
// Depends on ccirc_pkg, ccirc_req_if and ccirc_rsp_if.
//
// Takes one point triple per cycle while the output is not stalled, and
// returns one circle per triple, in order. The pipe is 3 product/sum stages, a
// load stage, one stage per quotient bit of the 42-bit restoring divider, 5
// stages of center and squared-distance math, one stage per root bit of the
// 25-bit square root, and the output register. The whole pipe advances when
// the output register is empty or taken, so req ready drops only while a
// result waits at the output.
// Collinear points give valid_res = 0 with all other fields zero. Centers are
// rounded to nearest (ties away from zero) in 1/16 pixel and saturated; the
// radius is rounded to nearest and saturates high.
`default_nettype none
module circumcircle_three_points import ccirc_pkg::*; (
   input  wire             clock,
   input  wire             reset,
   ccirc_req_if.sink       req_bus,
   ccirc_rsp_if.source     rsp_bus
);
   localparam int CW = COORD_BITS;
   localparam logic signed [CXW-1:0] SMAX = CXW'((64'sd1 <<< (OUT_BITS - 1)) - 1);
   localparam logic signed [CXW-1:0] SMIN = -CXW'(64'sd1 <<< (OUT_BITS - 1));
   localparam logic [XW-1:0]  UMAX_X = XW'((64'd1 << OUT_BITS) - 1);
   localparam logic [RTW:0]   UMAX_R = (RTW + 1)'((64'd1 << OUT_BITS) - 1);

   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type o;
      logic [DMW:0]  tx;
      logic [DMW:0]  ty;
      o  = s;
      tx = {s.rx, s.qx[QW-1]};
      ty = {s.ry, s.qy[QW-1]};
      o.qx = {s.qx[QW-2:0], tx >= {1'b0, s.den}};
      o.qy = {s.qy[QW-2:0], ty >= {1'b0, s.den}};
      if (tx >= {1'b0, s.den}) begin
         tx = tx - {1'b0, s.den};
      end
      if (ty >= {1'b0, s.den}) begin
         ty = ty - {1'b0, s.den};
      end
      o.rx = tx[DMW-1:0];
      o.ry = ty[DMW-1:0];
      return o;
   endfunction

   function automatic sq_stage_type sq_step(input sq_stage_type s);
      sq_stage_type o;
      logic [RW+1:0] t;
      logic [RW+1:0] trial;
      o     = s;
      t     = {s.rem, s.sv[SQE-1 -: 2]};
      trial = {2'b00, s.root, 2'b01};
      if (t >= trial) begin
         t      = t - trial;
         o.root = {s.root[RTW-2:0], 1'b1};
      end else begin
         o.root = {s.root[RTW-2:0], 1'b0};
      end
      o.rem = t[RW-1:0];
      o.sv  = {s.sv[SQE-3:0], 2'b00};
      return o;
   endfunction

   function automatic logic [OUT_BITS-1:0] sat_s(input logic signed [CXW-1:0] v);
      if (v > SMAX) begin
         return SMAX[OUT_BITS-1:0];
      end else if (v < SMIN) begin
         return SMIN[OUT_BITS-1:0];
      end
      return v[OUT_BITS-1:0];
   endfunction

   logic adv;
   logic out_v_ff;

   assign adv           = !out_v_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // stage 1: differences and squared norms
   logic v1_ff;
   logic [CW-1:0] x1_1_ff, y1_1_ff, x1_1_in, y1_1_in;
   logic [CW-1:0] xa_1_ff, xb_1_ff, xc_1_ff;
   logic signed [CW:0] dy23_ff, dy31_ff, dy12_ff, dx32_ff, dx13_ff, dx21_ff;
   logic [SW-1:0] s1_ff, s2_ff, s3_ff;

   assign x1_1_in = req_bus.first_x;
   assign y1_1_in = req_bus.first_y;

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_1_ff <= x1_1_in;
         y1_1_ff <= y1_1_in;
         xa_1_ff <= req_bus.first_x;
         xb_1_ff <= req_bus.second_x;
         xc_1_ff <= req_bus.third_x;
         dy23_ff <= $signed({1'b0, req_bus.second_y}) - $signed({1'b0, req_bus.third_y});
         dy31_ff <= $signed({1'b0, req_bus.third_y}) - $signed({1'b0, req_bus.first_y});
         dy12_ff <= $signed({1'b0, req_bus.first_y}) - $signed({1'b0, req_bus.second_y});
         dx32_ff <= $signed({1'b0, req_bus.third_x}) - $signed({1'b0, req_bus.second_x});
         dx13_ff <= $signed({1'b0, req_bus.first_x}) - $signed({1'b0, req_bus.third_x});
         dx21_ff <= $signed({1'b0, req_bus.second_x}) - $signed({1'b0, req_bus.first_x});
         s1_ff   <= SW'(req_bus.first_x * req_bus.first_x)
                    + SW'(req_bus.first_y * req_bus.first_y);
         s2_ff   <= SW'(req_bus.second_x * req_bus.second_x)
                    + SW'(req_bus.second_y * req_bus.second_y);
         s3_ff   <= SW'(req_bus.third_x * req_bus.third_x)
                    + SW'(req_bus.third_y * req_bus.third_y);
      end
   end

   // stage 2: products
   logic v2_ff;
   logic [CW-1:0] x1_2_ff, y1_2_ff;
   logic signed [PAW-1:0] pa1_ff, pa2_ff, pa3_ff;
   logic signed [PBW-1:0] pb1_ff, pb2_ff, pb3_ff, pc1_ff, pc2_ff, pc3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_2_ff <= x1_1_ff;
         y1_2_ff <= y1_1_ff;
         pa1_ff  <= $signed({1'b0, xa_1_ff}) * dy23_ff;
         pa2_ff  <= $signed({1'b0, xb_1_ff}) * dy31_ff;
         pa3_ff  <= $signed({1'b0, xc_1_ff}) * dy12_ff;
         pb1_ff  <= $signed({1'b0, s1_ff}) * dy23_ff;
         pb2_ff  <= $signed({1'b0, s2_ff}) * dy31_ff;
         pb3_ff  <= $signed({1'b0, s3_ff}) * dy12_ff;
         pc1_ff  <= $signed({1'b0, s1_ff}) * dx32_ff;
         pc2_ff  <= $signed({1'b0, s2_ff}) * dx13_ff;
         pc3_ff  <= $signed({1'b0, s3_ff}) * dx21_ff;
      end
   end

   // stage 3: A, -B, -C
   logic v3_ff;
   logic [CW-1:0] x1_3_ff, y1_3_ff;
   logic signed [AW-1:0] a_ff;
   logic signed [BW-1:0] nb_ff, nc_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_3_ff <= x1_2_ff;
         y1_3_ff <= y1_2_ff;
         a_ff    <= AW'(pa1_ff) + AW'(pa2_ff) + AW'(pa3_ff);
         nb_ff   <= BW'(pb1_ff) + BW'(pb2_ff) + BW'(pb3_ff);
         nc_ff   <= BW'(pc1_ff) + BW'(pc2_ff) + BW'(pc3_ff);
      end
   end

   // divider load: magnitudes with half the divisor added for rounding
   logic signed [NW-1:0] numx, numy;
   logic [NW-1:0]        magx, magy;
   logic [AW-1:0]        maga;
   div_stage_type        div_in;

   always_comb begin
      numx        = NW'(nb_ff) <<< FRAC_BITS;
      numy        = NW'(nc_ff) <<< FRAC_BITS;
      magx        = numx[NW-1] ? NW'(-numx) : NW'(numx);
      magy        = numy[NW-1] ? NW'(-numy) : NW'(numy);
      maga        = a_ff[AW-1] ? AW'(-a_ff) : AW'(a_ff);
      div_in.rx   = '0;
      div_in.ry   = '0;
      div_in.qx   = QW'(magx) + QW'(maga);
      div_in.qy   = QW'(magy) + QW'(maga);
      div_in.den  = {maga, 1'b0};
      div_in.negx = numx[NW-1] ^ a_ff[AW-1];
      div_in.negy = numy[NW-1] ^ a_ff[AW-1];
      div_in.x1   = x1_3_ff;
      div_in.y1   = y1_3_ff;
      div_in.vres = (a_ff != '0);
   end

   div_stage_type div_ff [0:QW];
   logic          dv_ff  [0:QW];

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0] <= div_in;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[k+1] <= div_step(div_ff[k]);
         end
      end
   end

   // post stages: signed centers, offsets, saturation, squares
   logic v5_ff, v6_ff, v7_ff, v8_ff;
   logic signed [CXW-1:0] cx5_ff, cy5_ff;
   logic [CW-1:0]         x1_5_ff, y1_5_ff;
   logic                  vres5_ff, vres6_ff, vres7_ff, vres8_ff;
   logic [OUT_BITS-1:0]   cx6_ff, cy6_ff, cx7_ff, cy7_ff, cx8_ff, cy8_ff;
   logic signed [XW-1:0]  dx6_ff, dy6_ff;
   logic [XW-1:0]         adx, ady;
   logic [OUT_BITS-1:0]   adx7_ff, ady7_ff;
   logic                  rsat7_ff, rsat8_ff;
   logic [2*OUT_BITS-1:0] sqx8_ff, sqy8_ff;
   sq_stage_type          sq_in;

   assign adx = dx6_ff[XW-1] ? XW'(-dx6_ff) : XW'(dx6_ff);
   assign ady = dy6_ff[XW-1] ? XW'(-dy6_ff) : XW'(dy6_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         cx5_ff   <= div_ff[QW].negx ? -$signed({1'b0, div_ff[QW].qx})
                                     : $signed({1'b0, div_ff[QW].qx});
         cy5_ff   <= div_ff[QW].negy ? -$signed({1'b0, div_ff[QW].qy})
                                     : $signed({1'b0, div_ff[QW].qy});
         x1_5_ff  <= div_ff[QW].x1;
         y1_5_ff  <= div_ff[QW].y1;
         vres5_ff <= div_ff[QW].vres;

         cx6_ff   <= sat_s(cx5_ff);
         cy6_ff   <= sat_s(cy5_ff);
         dx6_ff   <= XW'(cx5_ff) - $signed(XW'({x1_5_ff, FRAC_BITS'(0)}));
         dy6_ff   <= XW'(cy5_ff) - $signed(XW'({y1_5_ff, FRAC_BITS'(0)}));
         vres6_ff <= vres5_ff;

         adx7_ff  <= adx[OUT_BITS-1:0];
         ady7_ff  <= ady[OUT_BITS-1:0];
         rsat7_ff <= (adx > UMAX_X) || (ady > UMAX_X);
         cx7_ff   <= cx6_ff;
         cy7_ff   <= cy6_ff;
         vres7_ff <= vres6_ff;

         sqx8_ff  <= adx7_ff * adx7_ff;
         sqy8_ff  <= ady7_ff * ady7_ff;
         rsat8_ff <= rsat7_ff;
         cx8_ff   <= cx7_ff;
         cy8_ff   <= cy7_ff;
         vres8_ff <= vres7_ff;
      end
   end

   always_comb begin
      sq_in.rem  = '0;
      sq_in.root = '0;
      sq_in.sv   = SQE'(sqx8_ff) + SQE'(sqy8_ff);
      sq_in.vres = vres8_ff;
      sq_in.rsat = rsat8_ff;
      sq_in.cx   = cx8_ff;
      sq_in.cy   = cy8_ff;
   end

   sq_stage_type sq_ff [0:SQN];
   logic         sv_ff [0:SQN];

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff[0] <= sq_in;
      end
   end

   for (genvar k = 0; k < SQN; k++) begin : g_sq
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ff[k+1] <= sq_step(sq_ff[k]);
         end
      end
   end

   // round the root up when the remainder exceeds it, then clamp
   logic [RTW:0]          rnd;
   logic [OUT_BITS-1:0]   rad_in;
   logic                  vres_out_ff;
   logic [OUT_BITS-1:0]   cx_out_ff, cy_out_ff, rad_out_ff;

   always_comb begin
      rnd = {1'b0, sq_ff[SQN].root}
            + (RTW + 1)'(sq_ff[SQN].rem > {2'b00, sq_ff[SQN].root});
      if (sq_ff[SQN].rsat || rnd > UMAX_R) begin
         rad_in = UMAX_R[OUT_BITS-1:0];
      end else begin
         rad_in = rnd[OUT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vres_out_ff <= sq_ff[SQN].vres;
         cx_out_ff   <= sq_ff[SQN].vres ? sq_ff[SQN].cx : '0;
         cy_out_ff   <= sq_ff[SQN].vres ? sq_ff[SQN].cy : '0;
         rad_out_ff  <= sq_ff[SQN].vres ? rad_in : '0;
      end
   end

   // valid bits travel alongside the payload
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         v5_ff <= 1'b0; v6_ff <= 1'b0; v7_ff <= 1'b0; v8_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v1_ff    <= req_bus.valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v5_ff    <= dv_ff[QW];
         v6_ff    <= v5_ff;
         v7_ff    <= v6_ff;
         v8_ff    <= v7_ff;
         out_v_ff <= sv_ff[SQN];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
         sv_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= v3_ff;
         sv_ff[0] <= v8_ff;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_dv
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_ff[k+1] <= dv_ff[k];
         end
      end
   end

   for (genvar k = 0; k < SQN; k++) begin : g_sv
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sv_ff[k+1] <= sv_ff[k];
         end
      end
   end

   assign rsp_bus.valid     = out_v_ff;
   assign rsp_bus.valid_res = vres_out_ff;
   assign rsp_bus.center_x  = $signed(cx_out_ff);
   assign rsp_bus.center_y  = $signed(cy_out_ff);
   assign rsp_bus.radius    = rad_out_ff;
endmodule
`default_nettype wire

[rtl/ccirc_checker.sv]
// Port-level checks for circumcircle_three_points, bound to the top level.
// Depends on ccirc_pkg for the output width.
`default_nettype none
module ccirc_checker import ccirc_pkg::*; (
   input wire                clock,
   input wire                reset,
   input wire                req_ready,
   input wire                rsp_valid,
   input wire                rsp_ready,
   input wire                valid_res,
   input wire [OUT_BITS-1:0] center_x,
   input wire [OUT_BITS-1:0] center_y,
   input wire [OUT_BITS-1:0] radius
);
   // a waiting result stalls the whole pipe
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while a result waits");

   // hold a stalled beat
   a_stalled_beat_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(radius) && $stable(center_x)
         && $stable(center_y) && $stable(valid_res))
      else $error("stalled result beat changed");

   a_collinear_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !valid_res |-> center_x == '0 && center_y == '0 && radius == '0)
      else $error("collinear result carries nonzero fields");

   a_no_result_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
endmodule

bind circumcircle_three_points ccirc_checker u_ccirc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .valid_res (rsp_bus.valid_res),
   .center_x  (rsp_bus.center_x),
   .center_y  (rsp_bus.center_y),
   .radius    (rsp_bus.radius)
);
`default_nettype wire

[verif/circumcircle_three_points_tb.sv]
// Self-checking testbench for circumcircle_three_points: point triples in, circles out.
// Depends on ccirc_pkg, ccirc_req_if, ccirc_rsp_if and the circumcircle_three_points RTL.
`default_nettype none
module circumcircle_three_points_tb;
   import ccirc_pkg::*;

   localparam int CMAX      = (1 << COORD_BITS) - 1;
   localparam int STALL_MAX = 3000;

   typedef struct {
      logic                       valid_res;
      logic signed [OUT_BITS-1:0] center_x;
      logic signed [OUT_BITS-1:0] center_y;
      logic [OUT_BITS-1:0]        radius;
   } circle_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   ccirc_req_if req_bus ();
   ccirc_rsp_if rsp_bus ();

   circumcircle_three_points dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   circle_type circle_queue[$];
   int         fail_count   = 0;
   int         send_idle    = 0;
   int         recv_idle    = 0;
   int         quiet_cycles = 0;

   function automatic longint round_div(longint num, longint den);
      bit      neg;
      longint  q;
      neg = 1'b0;
      if (den < 0) begin
         den = -den;
         neg = ~neg;
      end
      if (num < 0) begin
         num = -num;
         neg = ~neg;
      end
      q = (num + den / 2) / den;
      return neg ? -q : q;
   endfunction

   function automatic longint round_sqrt(longint s);
      longint r;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= s)
            r = r + (64'sd1 << b);
      end
      if (s - r * r > r) r++;
      return r;
   endfunction

   function automatic longint clamp_s24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic circle_type predict_circle(int x1, int y1, int x2, int y2, int x3, int y3);
      circle_type c;
      longint  a, b, cc, s1, s2, s3, cxq, cyq, dx, dy, rad;
      longint  scale;
      scale = 64'sd1 << FRAC_BITS;
      c = '{1'b0, '0, '0, '0};
      a = longint'(x1) * (y2 - y3) - longint'(y1) * (x2 - x3)
          + longint'(x2) * y3 - longint'(x3) * y2;
      if (a == 0) return c;
      s1 = longint'(x1) * x1 + longint'(y1) * y1;
      s2 = longint'(x2) * x2 + longint'(y2) * y2;
      s3 = longint'(x3) * x3 + longint'(y3) * y3;
      b  = s1 * (y3 - y2) + s2 * (y1 - y3) + s3 * (y2 - y1);
      cc = s1 * (x2 - x3) + s2 * (x3 - x1) + s3 * (x1 - x2);
      cxq = round_div(-b * scale, 2 * a);
      cyq = round_div(-cc * scale, 2 * a);
      // radius uses the rounded but unsaturated center
      dx = cxq - x1 * scale;
      dy = cyq - y1 * scale;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dx > 16777215 || dy > 16777215) begin
         rad = 16777215;
      end else begin
         rad = round_sqrt(dx * dx + dy * dy);
         if (rad > 16777215) rad = 16777215;
      end
      c.valid_res = 1'b1;
      c.center_x  = OUT_BITS'(clamp_s24(cxq));
      c.center_y  = OUT_BITS'(clamp_s24(cyq));
      c.radius    = OUT_BITS'(rad);
      return c;
   endfunction

   initial begin
      req_bus.valid    = 1'b0;
      req_bus.first_x  = '0;
      req_bus.first_y  = '0;
      req_bus.second_x = '0;
      req_bus.second_y = '0;
      req_bus.third_x  = '0;
      req_bus.third_y  = '0;
      rsp_bus.ready    = 1'b0;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle);
   end

   // drive one beat; the predictor runs on acceptance
   task automatic send_points(int x1, int y1, int x2, int y2, int x3, int y3);
      req_bus.valid    <= 1'b1;
      req_bus.first_x  <= COORD_BITS'(x1);
      req_bus.first_y  <= COORD_BITS'(y1);
      req_bus.second_x <= COORD_BITS'(x2);
      req_bus.second_y <= COORD_BITS'(y2);
      req_bus.third_x  <= COORD_BITS'(x3);
      req_bus.third_y  <= COORD_BITS'(y3);
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      circle_queue = {circle_queue, predict_circle(x1, y1, x2, y2, x3, y3)};
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      circle_type exp_c;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (circle_queue.size() == 0) begin
            $display("%0t: unexpected circle vr=%0b cx=%0d cy=%0d r=%0d", $time,
                     rsp_bus.valid_res, rsp_bus.center_x, rsp_bus.center_y, rsp_bus.radius);
            fail_count++;
         end else begin
            exp_c = circle_queue.pop_front();
            if (rsp_bus.valid_res !== exp_c.valid_res || rsp_bus.center_x !== exp_c.center_x
                || rsp_bus.center_y !== exp_c.center_y || rsp_bus.radius !== exp_c.radius) begin
               $display("%0t: expected vr=%0b cx=%0d cy=%0d r=%0d, got vr=%0b cx=%0d cy=%0d r=%0d",
                        $time, exp_c.valid_res, exp_c.center_x, exp_c.center_y, exp_c.radius,
                        rsp_bus.valid_res, rsp_bus.center_x, rsp_bus.center_y, rsp_bus.radius);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (!req_bus.valid && circle_queue.size() == 0))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic test_collinear();
      send_points(0, 0, 0, 0, 0, 0);
      send_points(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
      send_points(0, 0, 1024, 1024, CMAX, CMAX);
      send_points(5, 7, 5, 900, 5, CMAX);
      send_points(0, 300, CMAX, 300, 77, 300);
      send_points(10, 10, 10, 10, 500, 3);
   endtask

   task automatic test_extremes();
      send_points(0, 0, CMAX, 0, 0, CMAX);
      send_points(CMAX, CMAX, 0, CMAX, CMAX, 0);
      send_points(0, 0, CMAX, CMAX, CMAX, 0);
      send_points(0, 0, 1, 0, 0, 1);
      send_points(0, 0, 2, 0, 1, 1);
      send_points(0, 0, 3, 0, 0, 1);
      send_points(1365, 682, 682, 1365, 1, 2);
   endtask

   // nearly collinear triples push the center and radius into saturation
   task automatic test_far_center();
      send_points(0, 0, 1, 0, CMAX, 1);
      send_points(0, 0, CMAX, 1, CMAX - 1, 1);
      send_points(CMAX, CMAX, 0, CMAX - 1, CMAX - 1, CMAX);
      send_points(0, CMAX, 1, CMAX, CMAX, CMAX - 1);
      send_points(CMAX, 0, CMAX, 1, CMAX - 1, CMAX);
      send_points(0, 0, 1024, 1, CMAX, 1);
   endtask

   task automatic test_random_phase(int count);
      int x1, y1, x2, y2, x3, y3, kind;
      for (int i = 0; i < count; i++) begin
         x1 = $urandom_range(CMAX);
         y1 = $urandom_range(CMAX);
         x2 = $urandom_range(CMAX);
         y2 = $urandom_range(CMAX);
         x3 = $urandom_range(CMAX);
         y3 = $urandom_range(CMAX);
         kind = $urandom_range(9);
         if (kind == 0) begin
            // midpoint of two points with even sums is collinear
            x2 = x2 ^ ((x1 ^ x2) & 1);
            y2 = y2 ^ ((y1 ^ y2) & 1);
            x3 = (x1 + x2) / 2;
            y3 = (y1 + y2) / 2;
         end else if (kind == 1) begin
            x3 = x1;
            y3 = y1;
         end else if (kind == 2) begin
            // small triangle, tiny determinant
            x2 = (x1 + $urandom_range(3)) & CMAX;
            y2 = (y1 + $urandom_range(3)) & CMAX;
            x3 = (x1 + $urandom_range(3)) & CMAX;
            y3 = (y1 + $urandom_range(3)) & CMAX;
         end
         send_points(x1, y1, x2, y2, x3, y3);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_collinear();
      test_extremes();
      test_far_center();
      send_idle = 38;
      recv_idle = 53;
      test_random_phase(270);
      send_idle = 53;
      recv_idle = 38;
      test_random_phase(270);
      send_idle = 0;
      recv_idle = 0;
      test_random_phase(260);
      req_bus.valid <= 1'b0;
      while (circle_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire
